// File: rtl/sdlp_pkg.sv
package sdlp_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned FLAGS_W = 5;

    typedef enum logic [1:0]
    {
        CMD_TICK = 2'd0,
        CMD_READ = 2'd1,
        CMD_INIT = 2'd2
    } cmd_t;

    localparam logic [1:0] CFG_SENSITIVITY = 2'd0;
    localparam logic [1:0] CFG_MONO_MODE   = 2'd1;
    localparam logic [1:0] CFG_MULTI_FUNC  = 2'd2;

    localparam logic [TICK_W-1:0] SENSITIVITY_RESET = 16'd50;

    // Sticky flag bit positions
    localparam int unsigned FLAG_PRESSED  = 0;
    localparam int unsigned FLAG_PHYSICAL = 1;
    localparam int unsigned FLAG_5S       = 2;
    localparam int unsigned FLAG_10S      = 3;
    localparam int unsigned FLAG_30S      = 4;

    localparam logic [TICK_W-1:0] HOLD_5S  = 16'd5000;
    localparam logic [TICK_W-1:0] HOLD_10S = 16'd10000;
    localparam logic [TICK_W-1:0] HOLD_30S = 16'd30000;
    localparam logic [TICK_W-1:0] HOLD_35S = 16'd35000;
    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

    typedef struct packed
    {
        logic [1:0]         command;
        logic               pin_level;
        logic [FLAGS_W-1:0] clear_mask;
    } in_item_t;

    typedef struct packed
    {
        logic toggle_state;
        logic physical_state;
        logic pressed_flag;
        logic physical_event_flag;
        logic hold5_flag;
        logic hold10_flag;
        logic hold30_flag;
    } out_item_t;

    typedef struct packed
    {
        logic [TICK_W-1:0] sensitivity_ms;
        logic              mono_mode;
        logic              multi_function;
    } cfg_t;

endpackage

// File: rtl/sdlp_core.sv
module sdlp_core
    import sdlp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic               ready_reg, ready_next;
    logic               logic_state_reg, logic_state_next;
    logic               reference_level_reg, reference_level_next;
    logic               accepted_level_reg, accepted_level_next;
    logic               timing_active_reg, timing_active_next;
    logic [TICK_W-1:0]  elapsed_ticks_reg, elapsed_ticks_next;
    logic               press_latched_reg, press_latched_next;
    logic [FLAGS_W-1:0] flags_reg, flags_next;

    logic [TICK_W-1:0]  elapsed_inc;
    logic [TICK_W-1:0]  elapsed_cand;
    logic [FLAGS_W-1:0] flags_out;

    assign elapsed_inc  = (elapsed_ticks_reg == TICK_MAX) ? TICK_MAX
                                                          : elapsed_ticks_reg + 16'd1;
    // first differing tick starts the count at zero
    assign elapsed_cand = timing_active_reg ? elapsed_inc : '0;

    always_comb
    begin
        ready_next           = ready_reg;
        logic_state_next     = logic_state_reg;
        reference_level_next = reference_level_reg;
        accepted_level_next  = accepted_level_reg;
        timing_active_next   = timing_active_reg;
        elapsed_ticks_next   = elapsed_ticks_reg;
        press_latched_next   = press_latched_reg;
        flags_next           = flags_reg;
        flags_out            = flags_reg;

        case (item.command)
            CMD_TICK:
            begin
                if (ready_reg)
                begin
                    if (item.pin_level != reference_level_reg)
                    begin
                        timing_active_next = 1'b1;
                        elapsed_ticks_next = elapsed_cand;
                        if (elapsed_cand >= cfg.sensitivity_ms)
                        begin
                            if (cfg.mono_mode)
                            begin
                                if (!press_latched_reg)
                                begin
                                    logic_state_next         = ~logic_state_reg;
                                    press_latched_next       = 1'b1;
                                    flags_next[FLAG_PRESSED]  = 1'b1;
                                    flags_next[FLAG_PHYSICAL] = 1'b1;
                                    accepted_level_next      = item.pin_level;
                                end
                            end
                            else
                            begin
                                logic_state_next          = ~logic_state_reg;
                                reference_level_next      = item.pin_level;
                                flags_next[FLAG_PRESSED]  = 1'b1;
                                flags_next[FLAG_PHYSICAL] = 1'b1;
                                accepted_level_next       = item.pin_level;
                                timing_active_next        = 1'b0;
                                elapsed_ticks_next        = '0;
                            end
                        end
                    end
                    else if (timing_active_reg)
                    begin
                        if (cfg.mono_mode)
                        begin
                            // release: classify hold time
                            if (cfg.multi_function)
                            begin
                                if (elapsed_inc >= HOLD_5S && elapsed_inc < HOLD_10S)
                                    flags_next[FLAG_5S] = 1'b1;
                                if (elapsed_inc >= HOLD_10S && elapsed_inc < HOLD_30S)
                                    flags_next[FLAG_10S] = 1'b1;
                                if (elapsed_inc >= HOLD_30S && elapsed_inc < HOLD_35S)
                                    flags_next[FLAG_30S] = 1'b1;
                            end
                            press_latched_next        = 1'b0;
                            flags_next[FLAG_PHYSICAL] = 1'b1;
                            accepted_level_next       = item.pin_level;
                        end
                        timing_active_next = 1'b0;
                        elapsed_ticks_next = '0;
                    end
                end
                flags_out = flags_next;
            end
            CMD_READ:
            begin
                flags_next = flags_reg & ~item.clear_mask;
            end
            CMD_INIT:
            begin
                reference_level_next = item.pin_level;
                accepted_level_next  = item.pin_level;
                logic_state_next     = item.pin_level;
                timing_active_next   = 1'b0;
                elapsed_ticks_next   = '0;
                press_latched_next   = 1'b0;
                ready_next           = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.toggle_state        = logic_state_next;
        result.physical_state      = accepted_level_next;
        result.pressed_flag        = flags_out[FLAG_PRESSED];
        result.physical_event_flag = flags_out[FLAG_PHYSICAL];
        result.hold5_flag          = flags_out[FLAG_5S];
        result.hold10_flag         = flags_out[FLAG_10S];
        result.hold30_flag         = flags_out[FLAG_30S];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg           <= 1'b0;
            logic_state_reg     <= 1'b0;
            reference_level_reg <= 1'b0;
            accepted_level_reg  <= 1'b0;
            timing_active_reg   <= 1'b0;
            elapsed_ticks_reg   <= '0;
            press_latched_reg   <= 1'b0;
            flags_reg           <= '0;
        end
        else if (en)
        begin
            ready_reg           <= ready_next;
            logic_state_reg     <= logic_state_next;
            reference_level_reg <= reference_level_next;
            accepted_level_reg  <= accepted_level_next;
            timing_active_reg   <= timing_active_next;
            elapsed_ticks_reg   <= elapsed_ticks_next;
            press_latched_reg   <= press_latched_next;
            flags_reg           <= flags_next;
        end
    end

    a_elapsed_needs_timing: assert property (@(posedge clk) disable iff (!rst_n)
        elapsed_ticks_reg != '0 |-> timing_active_reg)
        else $error("elapsed count running without active timing");

    a_idle_before_init: assert property (@(posedge clk) disable iff (!rst_n)
        !ready_reg |-> (!timing_active_reg && !press_latched_reg))
        else $error("timing state set before initialise");

    a_ready_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(ready_reg))
        else $error("ready dropped without reset");

endmodule

// File: rtl/switch_debounce_long_press.sv
// Switch debounce and long-press qualifier.
//
// Input channel (in_valid / in_stall / in_data): one item per transfer, a
// millisecond tick carrying the sampled pin, a read-and-clear of the sticky
// flags, or an initialise that loads the idle pin level. Ticks before the
// first initialise are ignored.
// Output channel (out_valid / out_stall / out_data): exactly one result per
// item, in order: toggle state, accepted physical level and the five flags.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
// sensitivity in ticks, 1 monostable mode, 2 hold classification enable.
// cfg_ready is always high; write only while no item is in flight.
//
// Two register stages: the input register, then the state update and the
// result register. out_valid rises once the item has passed from the input
// register into the result register. One item per cycle is sustained while
// out_stall is low; the state update is a combinational read-modify-write.
// A stalled result holds; one further item waits in the input register, then
// in_stall rises. Reset clears state, flags and both stages; configuration
// returns to 50 ticks, monostable, classification off.
module switch_debounce_long_press
    import sdlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [TICK_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;
    out_item_t core_result;
    logic      advance;
    logic      in_accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensitivity_ms <= SENSITIVITY_RESET;
            cfg_reg.mono_mode      <= 1'b1;
            cfg_reg.multi_function <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SENSITIVITY: cfg_reg.sensitivity_ms <= cfg_data;
                CFG_MONO_MODE:   cfg_reg.mono_mode      <= cfg_data[0];
                CFG_MULTI_FUNC:  cfg_reg.multi_function <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // item moves on when the result slot is free or being emptied
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign in_valid_next  = in_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= core_result;
    end

    sdlp_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_data_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_empty_slot_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("queued item did not reach the result register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room downstream");

    a_pending_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg)
        else $error("stalled item lost from input register");

endmodule
